FILE: rtl/htdot_pkg.sv
package htdot_pkg;

   // Fixed field widths.
   localparam int LUMA_W     = 8;
   localparam int LEVEL_BITS = 5;
   localparam int CELL_W     = 10;
   localparam int COORD_W    = 3;
   localparam int HALF_W     = 3;
   localparam int VALUE_W    = 8;

   // Default and reset value of the half size.
   localparam int MAX_HALF_SIZE_DEF = 4;
   localparam int HALF_RESET        = 4;

   // Supersampling grid and disk test.
   localparam int SUB        = 4;
   localparam int SUB_W      = 2;
   localparam int PY_W       = COORD_W + SUB_W;
   localparam int SQ_W       = 2 * PY_W;
   localparam int LVL_SQ_W   = 16;
   localparam int H_SQ_W     = 5;
   localparam int DIST_W     = 22;
   localparam int AREA_SCALE = 1600;
   localparam int LEVEL_BASE = 128;
   localparam int CNT_W      = 5;
   localparam int CNT_MAX    = 15;
   localparam int SHADE_W    = 4;

   // One pixel as it leaves the sequencer.
   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic [HALF_W-1:0]     half;
      logic [COORD_W-1:0]    row;
      logic [COORD_W-1:0]    col;
      logic                  border;
      logic [CELL_W-1:0]     cell_col;
      logic [CELL_W-1:0]     cell_row;
      logic                  last;
   } pix_type;

   // What travels beside the arithmetic through the pipeline.
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               border;
      logic [CELL_W-1:0]  cell_col;
      logic [CELL_W-1:0]  cell_row;
      logic               last;
   } meta_type;

endpackage

FILE: rtl/htdot_cov.sv
module htdot_cov (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pix_valid,
   input  htdot_pkg::pix_type            pix,
   output logic                          advance,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [htdot_pkg::VALUE_W-1:0] rsp_pixel_value,
   output logic [htdot_pkg::COORD_W-1:0] rsp_pixel_row,
   output logic [htdot_pkg::COORD_W-1:0] rsp_pixel_col,
   output logic [htdot_pkg::CELL_W-1:0]  rsp_out_cell_col,
   output logic [htdot_pkg::CELL_W-1:0]  rsp_out_cell_row,
   output logic                          rsp_last
);

   localparam int NHIT = htdot_pkg::SUB * htdot_pkg::SUB;

   // Stage 1: distances from the cell center, level square, half size square.
   logic                              s1_valid_ff;
   logic [htdot_pkg::COORD_W-1:0]     s1_dy_ff, s1_dx_ff;
   logic [htdot_pkg::LVL_SQ_W-1:0]    s1_lvl_sq_ff;
   logic [htdot_pkg::H_SQ_W-1:0]      s1_h_sq_ff;
   htdot_pkg::meta_type               s1_meta_ff;
   logic [htdot_pkg::COORD_W-1:0]     s1_dy_in, s1_dx_in, center;
   logic [htdot_pkg::LVL_SQ_W-1:0]    lvl_base, s1_lvl_sq_in;
   logic [htdot_pkg::H_SQ_W+1-1:0]    h_sq_full;
   htdot_pkg::meta_type               s1_meta_in;

   // Stage 2: radius limit and the squared subsample offsets.
   logic                              s2_valid_ff;
   logic [htdot_pkg::DIST_W-1:0]      s2_lim_ff, s2_lim_in;
   logic [htdot_pkg::SQ_W-1:0]        s2_sqy_ff [htdot_pkg::SUB];
   logic [htdot_pkg::SQ_W-1:0]        s2_sqx_ff [htdot_pkg::SUB];
   logic [htdot_pkg::SQ_W-1:0]        s2_sqy_in [htdot_pkg::SUB];
   logic [htdot_pkg::SQ_W-1:0]        s2_sqx_in [htdot_pkg::SUB];
   htdot_pkg::meta_type               s2_meta_ff;

   // Stage 3: one hit bit per subsample.
   logic                              s3_valid_ff;
   logic [NHIT-1:0]                   s3_hit_ff, s3_hit_in;
   htdot_pkg::meta_type               s3_meta_ff;

   // Stage 4: output register.
   logic                              s4_valid_ff;
   logic [htdot_pkg::VALUE_W-1:0]     s4_value_ff, s4_value_in;
   htdot_pkg::meta_type               s4_meta_ff;
   logic [htdot_pkg::CNT_W-1:0]       hit_count;
   logic [htdot_pkg::SHADE_W-1:0]     shade;

   // The whole pipeline moves unless a result waits on a stalled output.
   assign advance = !s4_valid_ff || !rsp_stall;

   always_comb begin
      center = pix.half - htdot_pkg::COORD_W'(1);
      s1_dy_in = (pix.row >= center) ? pix.row - center : center - pix.row;
      s1_dx_in = (pix.col >= center) ? pix.col - center : center - pix.col;
      lvl_base = htdot_pkg::LVL_SQ_W'(htdot_pkg::LEVEL_BASE)
               + htdot_pkg::LVL_SQ_W'(pix.level);
      s1_lvl_sq_in = lvl_base * lvl_base;
      h_sq_full = htdot_pkg::H_SQ_W'(pix.half) * htdot_pkg::H_SQ_W'(pix.half);
      s1_meta_in.row      = pix.row;
      s1_meta_in.col      = pix.col;
      s1_meta_in.border   = pix.border;
      s1_meta_in.cell_col = pix.cell_col;
      s1_meta_in.cell_row = pix.cell_row;
      s1_meta_in.last     = pix.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= pix_valid;
      end
      if (advance) begin
         s1_dy_ff     <= s1_dy_in;
         s1_dx_ff     <= s1_dx_in;
         s1_lvl_sq_ff <= s1_lvl_sq_in;
         s1_h_sq_ff   <= h_sq_full[htdot_pkg::H_SQ_W-1:0];
         s1_meta_ff   <= s1_meta_in;
      end
   end

   always_comb begin
      logic [htdot_pkg::SQ_W-1:0] py;
      logic [htdot_pkg::SQ_W-1:0] px;
      s2_lim_in = htdot_pkg::DIST_W'(s1_lvl_sq_ff) * htdot_pkg::DIST_W'(s1_h_sq_ff);
      for (int u = 0; u < htdot_pkg::SUB; u++) begin
         py = htdot_pkg::SQ_W'({s1_dy_ff, htdot_pkg::SUB_W'(u)});
         px = htdot_pkg::SQ_W'({s1_dx_ff, htdot_pkg::SUB_W'(u)});
         s2_sqy_in[u] = py * py;
         s2_sqx_in[u] = px * px;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_lim_ff  <= s2_lim_in;
         s2_sqy_ff  <= s2_sqy_in;
         s2_sqx_ff  <= s2_sqx_in;
         s2_meta_ff <= s1_meta_ff;
      end
   end

   // A subsample is inside the disk when 1600 times its squared distance
   // stays below the squared radius limit.
   always_comb begin
      logic [htdot_pkg::DIST_W-1:0] dist_sq;
      for (int u = 0; u < htdot_pkg::SUB; u++) begin
         for (int v = 0; v < htdot_pkg::SUB; v++) begin
            dist_sq = (htdot_pkg::DIST_W'(s2_sqy_ff[u]) + htdot_pkg::DIST_W'(s2_sqx_ff[v]))
                    * htdot_pkg::DIST_W'(htdot_pkg::AREA_SCALE);
            s3_hit_in[u*htdot_pkg::SUB + v] = (dist_sq < s2_lim_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_hit_ff  <= s3_hit_in;
         s3_meta_ff <= s2_meta_ff;
      end
   end

   always_comb begin
      hit_count = '0;
      for (int i = 0; i < NHIT; i++) begin
         hit_count = hit_count + htdot_pkg::CNT_W'(s3_hit_ff[i]);
      end
      if (hit_count > htdot_pkg::CNT_W'(htdot_pkg::CNT_MAX)) begin
         shade = htdot_pkg::SHADE_W'(htdot_pkg::CNT_MAX);
      end else begin
         shade = hit_count[htdot_pkg::SHADE_W-1:0];
      end
      s4_value_in = s3_meta_ff.border ? '0 : {shade, {htdot_pkg::SHADE_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_value_ff <= s4_value_in;
         s4_meta_ff  <= s3_meta_ff;
      end
   end

   assign rsp_valid        = s4_valid_ff;
   assign rsp_pixel_value  = s4_value_ff;
   assign rsp_pixel_row    = s4_meta_ff.row;
   assign rsp_pixel_col    = s4_meta_ff.col;
   assign rsp_out_cell_col = s4_meta_ff.cell_col;
   assign rsp_out_cell_row = s4_meta_ff.cell_row;
   assign rsp_last         = s4_meta_ff.last;

endmodule

FILE: rtl/halftone_dot_renderer_top.sv
// Each pixel of a cell passes from the sequencer registers through the pipeline to rsp.
// Throughput: one pixel per cycle unless rsp stalls; an item is 4*h*h pixels (4 to 64),
// set by the row and column sequencer that walks the dot cell; the next item is taken
// in the cycle that issues the previous cell's final pixel.
// Reset (synchronous, active high) empties the sequencer and the four pipeline stages and
// sets the half size register to 4.
module halftone_dot_renderer_top #(
   parameter int MAX_HALF_SIZE = htdot_pkg::MAX_HALF_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [htdot_pkg::LUMA_W-1:0]    req_sample_luma,
   input  logic [htdot_pkg::CELL_W-1:0]    req_cell_col,
   input  logic [htdot_pkg::CELL_W-1:0]    req_cell_row,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [htdot_pkg::VALUE_W-1:0]   rsp_pixel_value,
   output logic [htdot_pkg::COORD_W-1:0]   rsp_pixel_row,
   output logic [htdot_pkg::COORD_W-1:0]   rsp_pixel_col,
   output logic [htdot_pkg::CELL_W-1:0]    rsp_out_cell_col,
   output logic [htdot_pkg::CELL_W-1:0]    rsp_out_cell_row,
   output logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic [htdot_pkg::HALF_W-1:0]    csr_wr_data
);

   // The configured half size; the user must change it only while the block is idle, which
   // the block does not enforce. Each cell still latches its own copy when it is accepted.
   logic [htdot_pkg::HALF_W-1:0]     half_size_ff;
   logic [htdot_pkg::HALF_W-1:0]     half_eff;

   // Cell sequencer: holds the current cell and walks its pixels in raster order.
   logic                             busy_ff, busy_in;
   logic [htdot_pkg::COORD_W-1:0]    row_ff, row_in;
   logic [htdot_pkg::COORD_W-1:0]    col_ff, col_in;
   logic [htdot_pkg::COORD_W-1:0]    edge_max_ff, edge_max_in;
   logic [htdot_pkg::HALF_W-1:0]     half_ff, half_in;
   logic [htdot_pkg::LEVEL_BITS-1:0] level_ff, level_in;
   logic [htdot_pkg::CELL_W-1:0]     cell_col_ff, cell_col_in;
   logic [htdot_pkg::CELL_W-1:0]     cell_row_ff, cell_row_in;

   logic                             advance;
   logic                             issue;
   logic                             row_end;
   logic                             col_end;
   logic                             take;
   htdot_pkg::pix_type               pix;

   // A half size of zero acts as one; values above the maximum are clipped.
   always_comb begin
      if (half_size_ff == '0) begin
         half_eff = htdot_pkg::HALF_W'(1);
      end else if (half_size_ff > htdot_pkg::HALF_W'(MAX_HALF_SIZE)) begin
         half_eff = htdot_pkg::HALF_W'(MAX_HALF_SIZE);
      end else begin
         half_eff = half_size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_size_ff <= htdot_pkg::HALF_W'(htdot_pkg::HALF_RESET);
      end else if (csr_wr_en) begin
         half_size_ff <= csr_wr_data;
      end
   end

   // A pixel is issued into the pipeline in every cycle the pipeline moves
   // while a cell is in progress.
   assign issue   = busy_ff && advance;
   assign col_end = (col_ff == edge_max_ff);
   assign row_end = (row_ff == edge_max_ff);

   // A new item is taken when no cell is in progress, or when the current
   // cell's final pixel leaves for the pipeline in this cycle.
   assign req_stall = busy_ff && !(issue && row_end && col_end);
   assign take      = req_valid && !req_stall;

   always_comb begin
      busy_in     = busy_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      edge_max_in = edge_max_ff;
      half_in     = half_ff;
      level_in    = level_ff;
      cell_col_in = cell_col_ff;
      cell_row_in = cell_row_ff;
      if (issue) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_ff + htdot_pkg::COORD_W'(1);
            if (row_end) begin
               busy_in = 1'b0;
            end
         end else begin
            col_in = col_ff + htdot_pkg::COORD_W'(1);
         end
      end
      if (take) begin
         busy_in     = 1'b1;
         row_in      = '0;
         col_in      = '0;
         half_in     = half_eff;
         edge_max_in = htdot_pkg::COORD_W'({half_eff, 1'b0}) - htdot_pkg::COORD_W'(1);
         level_in    = req_sample_luma[htdot_pkg::LUMA_W-1 -: htdot_pkg::LEVEL_BITS];
         cell_col_in = req_cell_col;
         cell_row_in = req_cell_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      row_ff      <= row_in;
      col_ff      <= col_in;
      edge_max_ff <= edge_max_in;
      half_ff     <= half_in;
      level_ff    <= level_in;
      cell_col_ff <= cell_col_in;
      cell_row_ff <= cell_row_in;
   end

   // The last row and last column of every cell are forced to zero downstream.
   always_comb begin
      pix.level    = level_ff;
      pix.half     = half_ff;
      pix.row      = row_ff;
      pix.col      = col_ff;
      pix.border   = row_end || col_end;
      pix.cell_col = cell_col_ff;
      pix.cell_row = cell_row_ff;
      pix.last     = row_end && col_end;
   end

   // Four-stage coverage pipeline; its last stage is the output register.
   htdot_cov u_cov (
      .clock            (clock),
      .reset            (reset),
      .pix_valid        (busy_ff),
      .pix              (pix),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_pixel_col    (rsp_pixel_col),
      .rsp_out_cell_col (rsp_out_cell_col),
      .rsp_out_cell_row (rsp_out_cell_row),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: tb/tb_halftone_dot_renderer_top.sv
`timescale 1ns / 1ps

module tb_halftone_dot_renderer_top;

   // Widths and constants shared with the design.
   localparam int VALUE_W           = htdot_pkg::VALUE_W;
   localparam int COORD_W           = htdot_pkg::COORD_W;
   localparam int CELL_W            = htdot_pkg::CELL_W;
   localparam int LUMA_W            = htdot_pkg::LUMA_W;
   localparam int HALF_W            = htdot_pkg::HALF_W;
   localparam int HALF_RESET        = htdot_pkg::HALF_RESET;
   localparam int MAX_HALF_SIZE_DEF = htdot_pkg::MAX_HALF_SIZE_DEF;
   localparam int LEVEL_BITS        = htdot_pkg::LEVEL_BITS;
   localparam int LEVEL_BASE        = htdot_pkg::LEVEL_BASE;
   localparam int SUB               = htdot_pkg::SUB;
   localparam int AREA_SCALE        = htdot_pkg::AREA_SCALE;
   localparam int CNT_MAX           = htdot_pkg::CNT_MAX;
   localparam int SHADE_W           = htdot_pkg::SHADE_W;

   // One pixel of a dot cell as it should appear on the result channel.
   typedef struct {
      logic [VALUE_W-1:0] value;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [CELL_W-1:0]  cell_col;
      logic [CELL_W-1:0]  cell_row;
      logic               last;
   } dot_pixel_type;

   // One row of the directed stimulus. A negative half_write leaves the half size as it
   // is. A non-negative center_value is the typed-in shade of the only interior pixel of
   // a 2x2 cell; such rows are only used while the effective half size is 1.
   typedef struct {
      int               half_write;
      logic [LUMA_W-1:0] luma;
      logic [CELL_W-1:0] col;
      logic [CELL_W-1:0] row;
      int               center_value;
   } directed_row_type;

   localparam int CLOCK_HALF_NS = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_SEGMENTS = 5;
   localparam int CELLS_PER_SEGMENT = 30;

   // The clock, reset and every block input start from a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [LUMA_W-1:0] req_sample_luma = '0;
   logic [CELL_W-1:0] req_cell_col = '0;
   logic [CELL_W-1:0] req_cell_row = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [VALUE_W-1:0] rsp_pixel_value;
   logic [COORD_W-1:0] rsp_pixel_row;
   logic [COORD_W-1:0] rsp_pixel_col;
   logic [CELL_W-1:0] rsp_out_cell_col;
   logic [CELL_W-1:0] rsp_out_cell_row;
   logic rsp_last;
   logic csr_wr_en = 1'b0;
   logic [HALF_W-1:0] csr_wr_data = '0;

   // The testbench's own copy of the half size register. It changes only while the
   // block is idle, so the value at the moment a cell is accepted is the one it uses.
   logic [HALF_W-1:0] half_setting = HALF_W'(HALF_RESET);

   // Pixels that the accepted cells still owe, oldest first.
   dot_pixel_type pending_pixels[$];

   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   int error_count = 0;
   int cells_sent = 0;
   int pixels_checked = 0;
   bit [7:0] halves_seen = '0;

   halftone_dot_renderer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_luma  (req_sample_luma),
      .req_cell_col     (req_cell_col),
      .req_cell_row     (req_cell_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_pixel_col    (rsp_pixel_col),
      .rsp_out_cell_col (rsp_out_cell_col),
      .rsp_out_cell_row (rsp_out_cell_row),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // A free-running 8 ns clock.
   always begin
      #CLOCK_HALF_NS clock = 1'b1;
      #CLOCK_HALF_NS clock = 1'b0;
   end

   // Every mismatch goes through here so that the count and the log agree.
   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("pixel %0d field %s: got %0d, expected %0d",
                                   pixels_checked, name, got, want));
      end
   endtask

   // A register value of zero acts as one, and anything above the maximum acts as the
   // maximum.
   function automatic int unsigned effective_half(input logic [HALF_W-1:0] setting);
      int unsigned h;
      h = 32'(setting);
      if (h < 1) h = 1;
      if (h > MAX_HALF_SIZE_DEF) h = MAX_HALF_SIZE_DEF;
      return h;
   endfunction

   // Shade of one interior pixel: how many of its 4x4 sub-samples fall inside the disk,
   // clipped to 15 and scaled by 16. Both sides of the disk test are scaled to integers,
   // so the comparison is exact.
   function automatic logic [VALUE_W-1:0] disk_shade(input int unsigned h,
                                                     input int unsigned level,
                                                     input int unsigned dy,
                                                     input int unsigned dx);
      int unsigned radius_sq;
      int unsigned hits;
      int unsigned py;
      int unsigned px;
      radius_sq = h * h * (LEVEL_BASE + level) * (LEVEL_BASE + level);
      hits = 0;
      for (int unsigned u = 0; u < SUB; u++) begin
         for (int unsigned v = 0; v < SUB; v++) begin
            py = SUB * dy + u;
            px = SUB * dx + v;
            if (AREA_SCALE * (py * py + px * px) < radius_sq) hits++;
         end
      end
      if (hits > CNT_MAX) hits = CNT_MAX;
      return VALUE_W'(hits << SHADE_W);
   endfunction

   // Works out the whole dot cell for one accepted item and queues it in raster order.
   task automatic predict_dot_cell(input logic [LUMA_W-1:0] luma,
                                   input logic [CELL_W-1:0] col,
                                   input logic [CELL_W-1:0] row);
      int unsigned h;
      int unsigned cell_edge;
      int unsigned level;
      int unsigned dy;
      int unsigned dx;
      dot_pixel_type pix;
      h = effective_half(half_setting);
      cell_edge = 2 * h;
      level = 32'(luma) >> (LUMA_W - LEVEL_BITS);
      for (int unsigned r = 0; r < cell_edge; r++) begin
         for (int unsigned c = 0; c < cell_edge; c++) begin
            dy = (r >= h - 1) ? r - (h - 1) : (h - 1) - r;
            dx = (c >= h - 1) ? c - (h - 1) : (h - 1) - c;
            // The last row and the last column of a cell are always blank.
            if (r == cell_edge - 1 || c == cell_edge - 1) pix.value = '0;
            else pix.value = disk_shade(h, level, dy, dx);
            pix.row = COORD_W'(r);
            pix.col = COORD_W'(c);
            pix.cell_col = col;
            pix.cell_row = row;
            pix.last = (r == cell_edge - 1 && c == cell_edge - 1);
            pending_pixels.push_back(pix);
         end
      end
   endtask

   // Offers one cell on the request channel and queues what it must produce. Valid is
   // left high after acceptance so that a back-to-back item never toggles it within one
   // time step; it drops only when the sender decides to idle or the channel is closed.
   task automatic offer_cell(input logic [LUMA_W-1:0] luma,
                             input logic [CELL_W-1:0] col,
                             input logic [CELL_W-1:0] row,
                             input int center_value);
      dot_pixel_type pix;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_luma <= luma;
      req_cell_col <= col;
      req_cell_row <= row;
      do @(posedge clock); while (req_stall);
      cells_sent++;
      halves_seen[effective_half(half_setting)] = 1'b1;
      if (center_value >= 0) begin
         // A 2x2 cell has one interior pixel; the other three lie on the blank border.
         for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 2; c++) begin
               pix.value = (r == 0 && c == 0) ? VALUE_W'(center_value) : '0;
               pix.row = COORD_W'(r);
               pix.col = COORD_W'(c);
               pix.cell_col = col;
               pix.cell_row = row;
               pix.last = (r == 1 && c == 1);
               pending_pixels.push_back(pix);
            end
         end
      end else begin
         predict_dot_cell(luma, col, row);
      end
   endtask

   // The half size may only change once the block has nothing in flight. The request
   // channel is closed, every owed pixel is awaited, and a short pause covers the
   // pipeline before the write.
   task automatic write_half_size(input logic [HALF_W-1:0] setting);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= setting;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      half_setting = setting;
   endtask

   // Result side: the stall is redrawn every cycle, and every accepted pixel is checked
   // against the oldest one still owed. Both read the values from before the edge.
   always @(posedge clock) begin : result_side
      dot_pixel_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch($sformatf("pixel %0d arrived with nothing owed",
                                         pixels_checked));
            end else begin
               want = pending_pixels.pop_front();
               check_field("pixel_value", 32'(rsp_pixel_value), 32'(want.value));
               check_field("pixel_row", 32'(rsp_pixel_row), 32'(want.row));
               check_field("pixel_col", 32'(rsp_pixel_col), 32'(want.col));
               check_field("out_cell_col", 32'(rsp_out_cell_col), 32'(want.cell_col));
               check_field("out_cell_row", 32'(rsp_out_cell_row), 32'(want.cell_row));
               check_field("last", 32'(rsp_last), 32'(want.last));
            end
            pixels_checked++;
         end
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // Stimulus: reset, a directed list, then random cells under three idle patterns.
   initial begin : stimulus
      directed_row_type directed_rows[$];
      int idle_pattern[3][2];
      logic [HALF_W-1:0] next_half;

      // After reset the half size is 4, so the first rows walk full 8x8 cells with the
      // extreme luma values and the extreme cell indexes.
      directed_rows.push_back('{-1, 8'h00, 10'h000, 10'h000, -1});
      directed_rows.push_back('{-1, 8'hFF, 10'h3FF, 10'h3FF, -1});
      directed_rows.push_back('{-1, 8'h80, 10'h2AA, 10'h155, -1});
      directed_rows.push_back('{-1, 8'h07, 10'h155, 10'h2AA, -1});
      // At half size 1 the single interior pixel is easy to count by hand: the darkest
      // level covers 13 sub-samples, the brightest level 15.
      directed_rows.push_back('{1, 8'h00, 10'h000, 10'h3FF, 208});
      directed_rows.push_back('{-1, 8'hFF, 10'h3FF, 10'h000, 240});
      directed_rows.push_back('{-1, 8'h07, 10'h005, 10'h009, 208});
      directed_rows.push_back('{-1, 8'hF8, 10'h200, 10'h001, 240});
      // A half size of zero behaves as one.
      directed_rows.push_back('{0, 8'h00, 10'h001, 10'h200, 208});
      directed_rows.push_back('{-1, 8'hFF, 10'h3FE, 10'h3FD, 240});
      directed_rows.push_back('{-1, 8'h80, 10'h0F0, 10'h30F, -1});
      // The remaining sizes, including settings above the maximum, which act as four.
      directed_rows.push_back('{2, 8'h00, 10'h100, 10'h080, -1});
      directed_rows.push_back('{-1, 8'hFF, 10'h040, 10'h020, -1});
      directed_rows.push_back('{3, 8'h00, 10'h010, 10'h008, -1});
      directed_rows.push_back('{-1, 8'hFF, 10'h004, 10'h002, -1});
      directed_rows.push_back('{-1, 8'h5A, 10'h3C3, 10'h0A5, -1});
      directed_rows.push_back('{4, 8'h3C, 10'h1E1, 10'h21E, -1});
      directed_rows.push_back('{5, 8'h00, 10'h3FF, 10'h000, -1});
      directed_rows.push_back('{6, 8'hFF, 10'h000, 10'h3FF, -1});
      directed_rows.push_back('{7, 8'h80, 10'h155, 10'h155, -1});
      directed_rows.push_back('{-1, 8'h7F, 10'h2AA, 10'h2AA, -1});

      // Sender and receiver idle rates for the three random phases, in percent.
      idle_pattern = '{'{29, 45}, '{45, 29}, '{0, 0}};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The directed part runs without idling so that its cells follow each other closely.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].half_write >= 0) begin
            write_half_size(HALF_W'(directed_rows[i].half_write));
         end
         offer_cell(directed_rows[i].luma, directed_rows[i].col, directed_rows[i].row,
                    directed_rows[i].center_value);
      end

      // Random part. Each phase sets its idle rates and then steps through several half
      // sizes; the first two of each phase are the smallest and the largest cell.
      for (int phase = 0; phase < 3; phase++) begin
         for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            if (seg == 0) next_half = HALF_W'(1);
            else if (seg == 1) next_half = HALF_W'(MAX_HALF_SIZE_DEF);
            else next_half = HALF_W'($urandom_range(7));
            write_half_size(next_half);
            send_idle_pct = idle_pattern[phase][0];
            rcv_idle_pct = idle_pattern[phase][1];
            repeat (CELLS_PER_SEGMENT) begin
               offer_cell(LUMA_W'($urandom_range(255)), CELL_W'($urandom_range(1023)),
                          CELL_W'($urandom_range(1023)), -1);
            end
         end
      end

      // Close the request channel, let every owed pixel arrive, then watch a little longer
      // for anything extra.
      req_valid <= 1'b0;
      for (int k = 0; k < 20000 && pending_pixels.size() != 0; k++) @(posedge clock);
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         report_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));
      end

      $display("Ran %0d dot cells and checked %0d pixels, %0d mismatches.",
               cells_sent, pixels_checked, error_count);
      $display("Effective half sizes seen (bit per size): %b, idle patterns 29/45, 45/29, 0/0.",
               halves_seen[4:1]);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: several times the slowest expected run.
   initial begin : watchdog
      #3ms;
      $display("Timeout with %0d pixels still owed.", pending_pixels.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
